// File: rtl/core/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types, widths and cofactor index tables for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // Element and intermediate widths.
  localparam int unsigned ElemW  = 32;               // Q16.16 element
  localparam int unsigned CofW   = 64;               // Q32.32 cofactor
  localparam int unsigned TermW  = 96;               // element times cofactor
  localparam int unsigned DetW   = 98;               // exact Q50.48 determinant
  localparam int unsigned DmagW  = 97;               // determinant magnitude
  localparam int unsigned NElem  = 9;

  // Pipeline layout.
  localparam int unsigned FrontStg = 7;              // cofactor and determinant
  localparam int unsigned QuotW    = 32;             // quotient bits per lane
  localparam int unsigned LaneStg  = QuotW + 2;      // range check, steps, saturate
  localparam int unsigned PipeStg  = FrontStg + LaneStg;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;
  typedef logic [DmagW-1:0]        dmag_t;

  // Determinant status handed from the front end to the top level.
  typedef struct packed {
    logic dneg;
    logic singular;
  } det_info_t;

  // Cofactor k = m[A]*m[B] - m[C]*m[D], elements numbered row by row.
  localparam int unsigned CF_A [NElem] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned CF_B [NElem] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned CF_C [NElem] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned CF_D [NElem] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // Cofactors used by the row 0 expansion, one per row 0 element.
  localparam int unsigned DET_CF [3] = '{0, 3, 6};

  // Saturate a sign and a 65-bit magnitude to a signed 32-bit word.
  function automatic logic [ElemW-1:0] sat_word(input logic neg, input logic [64:0] mag);
    logic [ElemW-1:0] res;
    if (neg) begin
      if (mag > 65'h0_8000_0000) res = 32'h8000_0000;
      else                       res = 32'(-mag[ElemW-1:0]);
    end else begin
      if (mag > 65'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
      else                       res = mag[ElemW-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/core/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors and exact determinant, expanded along row 0, over seven stages.
// ----------------------------------------------------------------------------
module mi3_front import mi3_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  elem_t     m_in   [NElem],
  output logic [CofW-1:0] cmag [NElem],
  output logic      cneg   [NElem],
  output dmag_t     dmag,
  output det_info_t info
);

  elem_t                   m_r     [NElem];
  cof_t                    pl_r    [NElem];
  cof_t                    pr_r    [NElem];
  elem_t                   row1_r  [3];
  elem_t                   row2_r  [3];
  cof_t                    adj2_r  [NElem];
  cof_t                    adj3_r  [NElem];
  cof_t                    adj4_r  [NElem];
  cof_t                    adj5_r  [NElem];
  logic signed [64:0]      plo_r   [3];
  logic signed [63:0]      phi_r   [3];
  logic signed [TermW-1:0] term_r  [3];
  logic signed [DetW-1:0]  det_r;
  logic [CofW-1:0]         cmag_r  [NElem];
  logic                    cneg_r  [NElem];
  dmag_t                   dmag_r;
  det_info_t               info_r;

  // Stage 0: capture the matrix.
  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_in;
    end
  end

  // Stages 1 and 2: the two products of each cofactor, then their difference.
  for (genvar k = 0; k < NElem; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        pl_r[k]   <= cof_t'(m_r[CF_A[k]]) * cof_t'(m_r[CF_B[k]]);
        pr_r[k]   <= cof_t'(m_r[CF_C[k]]) * cof_t'(m_r[CF_D[k]]);
        adj2_r[k] <= pl_r[k] - pr_r[k];
        adj3_r[k] <= adj2_r[k];
        adj4_r[k] <= adj3_r[k];
        adj5_r[k] <= adj4_r[k];
      end
    end
  end

  // Row 0 travels beside the cofactor products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 3; t++) begin
        row1_r[t] <= m_r[t];
        row2_r[t] <= row1_r[t];
      end
    end
  end

  // Stages 3 and 4: element times cofactor as two 32-bit halves, then joined.
  // The high half of the cofactor is signed, the low half unsigned.
  for (genvar t = 0; t < 3; t++) begin : g_term
    logic signed [64:0] a_ext;
    logic signed [64:0] lo_ext;
    assign a_ext  = 65'(row2_r[t]);
    assign lo_ext = $signed({33'b0, adj2_r[DET_CF[t]][31:0]});
    always_ff @(posedge clk) begin
      if (en) begin
        plo_r[t]  <= a_ext * lo_ext;
        phi_r[t]  <= 64'(row2_r[t]) * 64'($signed(adj2_r[DET_CF[t]][63:32]));
        term_r[t] <= (TermW'(phi_r[t]) <<< 32) + TermW'(plo_r[t]);
      end
    end
  end

  // Stage 5: sum of the three terms.
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= DetW'(term_r[0]) + DetW'(term_r[1]) + DetW'(term_r[2]);
    end
  end

  // Stage 6: magnitudes and signs for the division lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      info_r.dneg     <= det_r[DetW-1];
      info_r.singular <= (det_r == '0);
      dmag_r          <= det_r[DetW-1] ? DmagW'(-det_r) : DmagW'(det_r);
      for (int k = 0; k < NElem; k++) begin
        cmag_r[k] <= adj5_r[k][CofW-1] ? CofW'(-adj5_r[k]) : CofW'(adj5_r[k]);
        cneg_r[k] <= adj5_r[k][CofW-1] ^ det_r[DetW-1];
      end
    end
  end

  assign cmag = cmag_r;
  assign cneg = cneg_r;
  assign dmag = dmag_r;
  assign info = info_r;

endmodule

// File: rtl/core/mi3_lane.sv
// ----------------------------------------------------------------------------
// mi3_lane
// One inverse element: (cofactor << 32) / determinant, restoring division with
// one quotient bit per stage, truncated toward zero and saturated to Q16.16.
// ----------------------------------------------------------------------------
module mi3_lane import mi3_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [CofW-1:0] cmag,
  input  logic            neg,
  input  dmag_t           dmag,
  output logic [ElemW-1:0] q_out
);

  dmag_t            r_r   [QuotW+1];
  dmag_t            d_r   [QuotW+1];
  logic [QuotW-1:0] q_r   [QuotW+1];
  logic             ovf_r [QuotW+1];
  logic             neg_r [QuotW+1];
  logic [ElemW-1:0] q_out_r;

  // Range check: a quotient of 2^32 or more saturates whatever the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= DmagW'(cmag);
      d_r[0]   <= dmag;
      q_r[0]   <= '0;
      ovf_r[0] <= (DmagW'(cmag) >= dmag);
      neg_r[0] <= neg;
    end
  end

  // One trial subtract per stage; the low numerator bits are all zero.
  for (genvar j = 1; j <= QuotW; j++) begin : g_step
    logic [DmagW:0] trial;
    logic           ge;
    assign trial = {r_r[j-1], 1'b0};
    assign ge    = (trial >= {1'b0, d_r[j-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j]   <= ge ? DmagW'(trial - {1'b0, d_r[j-1]}) : DmagW'(trial);
        d_r[j]   <= d_r[j-1];
        q_r[j]   <= {q_r[j-1][QuotW-2:0], ge};
        ovf_r[j] <= ovf_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  // Sign and saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      q_out_r <= sat_word(neg_r[QuotW], {ovf_r[QuotW], 32'b0, q_r[QuotW]});
    end
  end

  assign q_out = q_out_r;

endmodule

// File: rtl/core/matrix3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// 3x3 matrix inverse by the adjugate in Q16.16, with determinant and a
// singular flag. Nine division lanes run side by side.
//
//   channel  | direction | tdata                     | tuser
//   in_      | slave     | 9 elements, 288 bits      | none
//   out_     | master    | 9 inverse + det, 320 bits | singular
//
// From input word to output word a matrix passes seven stages of cofactor and
// determinant, 34 stages in each division lane (one quotient bit per stage)
// and the output register. One matrix is taken every cycle the pipeline runs.
// A skid register behind the output register absorbs one word when the
// consumer stalls; the pipeline holds only while the skid register is full.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module matrix3_inverse_core import mi3_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // in_r0c0, in_r0c1, ... in_r2c2, 32 bits each
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [319:0] out_tdata,  // out_r0c0, ... out_r2c2, det_value, 32 bits each
  output logic [0:0]   out_tuser   // singular
);

  logic             en;
  logic             v_r [PipeStg];
  elem_t            m_in [NElem];
  logic [CofW-1:0]  cmag [NElem];
  logic             cneg [NElem];
  dmag_t            dmag;
  det_info_t        info;
  logic [ElemW-1:0] q    [NElem];
  logic [ElemW-1:0] detv_r [LaneStg];
  logic             sing_r [LaneStg];
  logic [319:0]     pipe_d;
  logic [319:0]     out_d_r;
  logic             out_s_r;
  logic             out_v_r;
  logic [319:0]     sk_d_r;
  logic             sk_s_r;
  logic             sk_v_r;

  assign en        = !sk_v_r;
  assign in_tready = en;

  // Unpack the input word.
  for (genvar k = 0; k < NElem; k++) begin : g_unpack
    assign m_in[k] = in_tdata[k*ElemW +: ElemW];
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PipeStg; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int s = 1; s < PipeStg; s++) v_r[s] <= v_r[s-1];
    end
  end

  mi3_front u_front (
    .clk  (clk),
    .en   (en),
    .m_in (m_in),
    .cmag (cmag),
    .cneg (cneg),
    .dmag (dmag),
    .info (info)
  );

  for (genvar k = 0; k < NElem; k++) begin : g_lane
    mi3_lane u_lane (
      .clk   (clk),
      .en    (en),
      .cmag  (cmag[k]),
      .neg   (cneg[k]),
      .dmag  (dmag),
      .q_out (q[k])
    );
  end

  // Determinant output and singular flag, delayed to match the lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      detv_r[0] <= sat_word(info.dneg, dmag[DmagW-1:32]);
      sing_r[0] <= info.singular;
      for (int s = 1; s < LaneStg; s++) begin
        detv_r[s] <= detv_r[s-1];
        sing_r[s] <= sing_r[s-1];
      end
    end
  end

  // Merge the lanes into one word; a singular matrix gives all zeros.
  always_comb begin
    pipe_d = '0;
    if (!sing_r[LaneStg-1]) begin
      for (int k = 0; k < NElem; k++) pipe_d[k*ElemW +: ElemW] = q[k];
      pipe_d[NElem*ElemW +: ElemW] = detv_r[LaneStg-1];
    end
  end

  // Output register with skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (sk_v_r) begin
      if (out_tready) begin
        out_d_r <= sk_d_r;
        out_s_r <= sk_s_r;
        sk_v_r  <= 1'b0;
      end
    end else if (v_r[PipeStg-1]) begin
      if (!out_v_r || out_tready) begin
        out_d_r <= pipe_d;
        out_s_r <= sing_r[LaneStg-1];
        out_v_r <= 1'b1;
      end else begin
        sk_d_r <= pipe_d;
        sk_s_r <= sing_r[LaneStg-1];
        sk_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_d_r;
  assign out_tuser[0] = out_s_r;

`ifndef SYNTHESIS
  // A singular result carries an all-zero word.
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("singular result with nonzero data");

  // The skid register only fills behind a full output register.
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid word without output word");

  // The skid register fills only when the output was stalled.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid filled without a stall");
`endif

endmodule

// File: sim/matrix3_inverse_checker.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_checker
// Watches both stream channels of the 3x3 matrix inverse core. Each accepted
// input word is turned into an expected inverse, determinant and singular
// flag by an exact fixed-point computation; each accepted output word is
// compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module matrix3_inverse_checker import mi3_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [287:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [319:0] out_tdata,
  input  logic [0:0]   out_tuser,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [319:0] data;
    logic         singular;
  } inverse_t;

  inverse_t expected_q[$];
  int       out_seen;

  // Clamp a signed wide value to a signed 32-bit word.
  function automatic logic [31:0] clamp_word(input logic signed [191:0] v);
    if (v > 192'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -192'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Exact adjugate inverse of one matrix word.
  function automatic inverse_t invert_matrix(input logic [287:0] word);
    logic signed [191:0] m [9];
    logic signed [191:0] cof [9];
    logic signed [191:0] det, dabs, num, quo, dq;
    inverse_t r;
    for (int i = 0; i < 9; i++) m[i] = $signed(word[i*32 +: 32]);
    cof[0] = m[4]*m[8] - m[5]*m[7];
    cof[1] = m[2]*m[7] - m[1]*m[8];
    cof[2] = m[1]*m[5] - m[2]*m[4];
    cof[3] = m[5]*m[6] - m[3]*m[8];
    cof[4] = m[0]*m[8] - m[2]*m[6];
    cof[5] = m[2]*m[3] - m[0]*m[5];
    cof[6] = m[3]*m[7] - m[4]*m[6];
    cof[7] = m[1]*m[6] - m[0]*m[7];
    cof[8] = m[0]*m[4] - m[1]*m[3];
    det = m[0]*cof[0] + m[1]*cof[3] + m[2]*cof[6];
    r.data = '0;
    r.singular = (det == 0);
    if (r.singular) return r;
    // SystemVerilog signed division already truncates toward zero.
    dabs = (det < 0) ? -det : det;
    dq = dabs >>> 32;
    r.data[9*32 +: 32] = clamp_word((det < 0) ? -dq : dq);
    for (int i = 0; i < 9; i++) begin
      num = cof[i] <<< 32;
      quo = num / det;
      r.data[i*32 +: 32] = clamp_word(quo);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch word %0d %s: got %h expected %h", out_seen, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    out_seen = 0;
  end

  always @(posedge clk) begin
    inverse_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_q.push_back(invert_matrix(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected output word %0d", out_seen);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < 10; i++)
            if (out_tdata[i*32 +: 32] !== want.data[i*32 +: 32])
              report_mismatch(i == 9 ? "det_value" : $sformatf("element %0d", i),
                              out_tdata[i*32 +: 32], want.data[i*32 +: 32]);
          if (out_tuser[0] !== want.singular)
            report_mismatch("singular", 32'(out_tuser[0]), 32'(want.singular));
        end
        out_seen++;
      end
    end
    // Number of words still owed by the core.
    pending = expected_q.size();
  end
endmodule

// File: sim/matrix3_inverse_core_tb.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_core_tb
// Streams directed and random 3x3 matrices into the inverse core with random
// gaps and consumer stalls; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module matrix3_inverse_core_tb import mi3_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1400;
  localparam int Latency   = 42;
  localparam int CycleLimit = 400000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [319:0] out_tdata;
  logic [0:0]   out_tuser;
  int           fail_count, pending;
  int           cycles = 0;
  bit           calm = 0;
  logic [287:0] matrix_q[$];

  always #5 clk = ~clk;

  matrix3_inverse_core u_dut (.*);

  matrix3_inverse_checker u_chk (.*);

  // Runaway guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("matrix3_inverse_core_tb failed");
      $finish;
    end
  end

  // Consumer stalls in random bursts, none in the last part of the run.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 512)) - 256);
      3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      4: return 32'h0001_0000 * ($urandom_range(0, 4) - 2);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [287:0] pack9(input logic [31:0] e [9]);
    logic [287:0] w;
    for (int i = 0; i < 9; i++) w[i*32 +: 32] = e[i];
    return w;
  endfunction

  function automatic logic [287:0] rand_matrix();
    logic [31:0] e [9];
    int k;
    for (int i = 0; i < 9; i++) e[i] = rand_elem();
    k = $urandom_range(0, 9);
    // Some matrices are made singular by repeating a row or zeroing one.
    if (k == 0) for (int j = 0; j < 3; j++) e[6+j] = e[j];
    if (k == 1) for (int j = 0; j < 3; j++) e[3+j] = 0;
    // Small diagonal matrices give a tiny nonzero determinant.
    if (k == 2) begin
      foreach (e[i]) e[i] = 0;
      e[0] = $urandom_range(1, 255); e[4] = $urandom_range(1, 255);
      e[8] = $urandom_range(1, 255);
    end
    return pack9(e);
  endfunction

  task automatic send_matrix(input logic [287:0] w);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 11);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [31:0] e [9];
    logic [31:0] one = 32'h0001_0000;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed matrices: identity, zero, extremes, tiny and huge determinant.
    foreach (e[i]) e[i] = (i % 4 == 0) ? one : 0;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = 0;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = 32'h8000_0000;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = (i % 4 == 0) ? 32'h8000_0000 : 0;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = (i % 4 == 0) ? 32'h7FFF_FFFF : 0;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = (i % 4 == 0) ? 32'h0000_0001 : 0;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = (i % 4 == 0) ? -one : 0;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = (i % 4 == 0) ? 32'h0000_0100 : 32'h0000_0001;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = (i % 4 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = 32'hFFFF_FFFF;
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = one * (i + 1);
    matrix_q.push_back(pack9(e));
    foreach (e[i]) e[i] = (i == 0 || i == 4) ? one : ((i == 8) ? 32'h0000_0001 : 0);
    matrix_q.push_back(pack9(e));
    while (matrix_q.size() > 0) send_matrix(matrix_q.pop_front());

    // Random matrices; halfway the sender holds off until all results are back.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        in_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (n == NumRandom - 150) calm = 1;
      send_matrix(rand_matrix());
    end
    in_tvalid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("matrix3_inverse_core_tb passed");
    end else begin
      $display("matrix3_inverse_core_tb failed");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_front.sv
rtl/core/mi3_lane.sv
rtl/core/matrix3_inverse_core.sv
sim/matrix3_inverse_checker.sv
sim/matrix3_inverse_core_tb.sv
